[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the character sorter.
// Expects signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cisort_pkg.sv]
// Package for the case-insensitive character sorter.
// Holds the folded-key function, its constants and the cell control struct.
`default_nettype none
package cisort_pkg;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET   = 8'd32;

	typedef struct packed {
		logic insert;
		logic drain;
	} cisort_ctrl_t;

	function automatic logic [7:0] fold_key(input logic [7:0] c);
		logic [7:0] k;
		k = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			k = c + CASE_OFFSET;
		end
		return k;
	endfunction

endpackage
`default_nettype wire

[rtl/case_insensitive_char_sorter.sv]
// Case-insensitive stable character sorter: insertion chain of MAX_CHARS cells.
// Input: one character transfer per cycle while filling; tlast closes a string.
// Latency: first sorted result is offered the cycle after the closing transfer.
// Throughput: input is held off while the chain drains; one result per cycle
// while m_axis_tready is high, and an empty string still gives one result.
// Reset: arst_n clears state, count and overflow flag; cell bytes stay undefined.
`default_nettype none
`include "assert_macros.svh"
module case_insensitive_char_sorter
	import cisort_pkg::*;
#(
	parameter int MAX_CHARS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] char_in
	input  wire logic       s_axis_tuser,  // [0] has_char
	input  wire logic       s_axis_tlast,  // end_of_string
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] char_out
	output logic [1:0]      m_axis_tuser,  // [0] char_valid, [1] overflowed
	output logic            m_axis_tlast   // last_out
);

	localparam int CNT_W = $clog2(MAX_CHARS + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_CHARS);

	typedef enum logic {FILL, DRAIN} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic         s_xfer, m_xfer, full;
	cisort_ctrl_t ctrl;
	logic [MAX_CHARS-1:0] take;
	logic [7:0]           chars [MAX_CHARS];

	assign s_axis_tready = (state_q == FILL);
	assign m_axis_tvalid = (state_q == DRAIN);
	assign s_xfer = s_axis_tvalid && s_axis_tready;
	assign m_xfer = m_axis_tvalid && m_axis_tready;
	assign full = (count_q == FULL);

	assign ctrl.insert = s_xfer && s_axis_tuser && !full;
	assign ctrl.drain  = m_xfer && (count_q != '0);

	assign m_axis_tdata    = (count_q != '0) ? chars[0] : 8'h00;
	assign m_axis_tuser[0] = (count_q != '0);
	assign m_axis_tuser[1] = ovf_q;
	assign m_axis_tlast    = (count_q <= CNT_W'(1));

	for (genvar i = 0; i < MAX_CHARS; i++) begin : g_cell
		logic       prev_take;
		logic [7:0] prev_char, next_char;
		if (i == 0) begin : g_head
			assign prev_take = 1'b0;
			assign prev_char = 8'h00;
		end else begin : g_body
			assign prev_take = take[i-1];
			assign prev_char = chars[i-1];
		end
		if (i == MAX_CHARS - 1) begin : g_tail
			assign next_char = 8'h00;
		end else begin : g_mid
			assign next_char = chars[i+1];
		end
		cisort_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.char_in   (s_axis_tdata),
			.in_use    (count_q > CNT_W'(i)),
			.prev_take (prev_take),
			.prev_char (prev_char),
			.next_char (next_char),
			.take      (take[i]),
			.held      (chars[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FILL;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				FILL: begin
					if (ctrl.insert) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (s_xfer && s_axis_tuser && full) begin
						ovf_q <= 1'b1;
					end
					if (s_xfer && s_axis_tlast) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (ctrl.drain) begin
						count_q <= count_q - CNT_W'(1);
					end
					if (m_xfer && m_axis_tlast) begin
						state_q <= FILL;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= FILL;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_count_bound, count_q <= FULL, "character count above capacity")
	`ASSERT_NEXT(a_last_empties, m_xfer && m_axis_tlast, count_q == '0 && !ovf_q,
		"chain not empty after last transfer")
	`ASSERT_IMPLIES(a_head_sorted, count_q >= CNT_W'(2),
		fold_key(chars[0]) <= fold_key(chars[1]), "head cells out of order")
	`ASSERT_IMPLIES(a_ovf_when_full, $rose(ovf_q), count_q == FULL,
		"overflow flagged below capacity")

endmodule
`default_nettype wire

[rtl/cisort_cell.sv]
// One cell of the insertion-sort chain: holds a character byte.
// Depends on cisort_pkg for the folded key and the control struct.
`default_nettype none
module cisort_cell
	import cisort_pkg::*;
(
	input  wire logic         clk,
	input  wire cisort_ctrl_t ctrl,
	input  wire logic [7:0]   char_in,
	input  wire logic         in_use,
	input  wire logic         prev_take,
	input  wire logic [7:0]   prev_char,
	input  wire logic [7:0]   next_char,
	output logic              take,
	output logic [7:0]        held
);

	logic [7:0] char_q;

	// strict compare keeps equal keys in arrival order
	assign take = !in_use || (fold_key(char_q) > fold_key(char_in));
	assign held = char_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert && take) begin
			char_q <= prev_take ? prev_char : char_in;
		end else if (ctrl.drain) begin
			char_q <= next_char;
		end
	end

endmodule
`default_nettype wire
